>>> hw/rtl/nsgc_pkg.sv
// Shared types, constants and helper functions for the NMEA sentence group checker.
`default_nettype none

package nsgc_pkg;

  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_STAR = 8'h2A;

  localparam logic [7:0] PREFIX_LEN = 8'd6;

  localparam logic [7:0] LINE_BYTES_RST = 8'd82;
  localparam logic [3:0] GROUP_SIZE_RST = 4'd6;
  localparam logic [3:0] GROUP_SIZE_MAX = 4'd8;

  // configuration register indexes
  localparam logic CFG_MAX_LINE_BYTES      = 1'b0;
  localparam logic CFG_SENTENCES_PER_GROUP = 1'b1;

  // checksum field parse phase
  localparam logic [1:0] HEX_NONE    = 2'd0;
  localparam logic [1:0] HEX_DIGITS  = 2'd1;
  localparam logic [1:0] HEX_STOPPED = 2'd2;

  typedef enum logic [1:0] {
    STATUS_VALID    = 2'd0,
    STATUS_TOKENS   = 2'd1,
    STATUS_CHECKSUM = 2'd2
  } status_t;

  // end-of-line report from the scanner to the group tracker
  typedef struct packed {
    logic    ended;
    logic    rmc;
    status_t verdict;
  } line_end_t;

  function automatic logic [7:0] rmc_prefix_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h24; // $
      3'd1:    c = 8'h47; // G
      3'd2:    c = 8'h50; // P
      3'd3:    c = 8'h52; // R
      3'd4:    c = 8'h4D; // M
      3'd5:    c = 8'h43; // C
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // {is_digit, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] d;
    if (b inside {[8'h30:8'h39]}) begin
      d = {1'b1, b[3:0]};
    end else if (b inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      d = {1'b1, b[3:0] + 4'd9};
    end else begin
      d = 5'd0;
    end
    return d;
  endfunction

  function automatic status_t line_verdict(input logic [1:0] star_count,
                                           input logic       tail_nonempty,
                                           input logic       hex_overflow,
                                           input logic [7:0] hex_value,
                                           input logic [7:0] xor_acc);
    logic two;
    status_t v;
    two = (star_count == 2'd1 && tail_nonempty) || (star_count == 2'd2 && !tail_nonempty);
    if (!two) begin
      v = STATUS_TOKENS;
    end else if (hex_overflow || hex_value != xor_acc) begin
      v = STATUS_CHECKSUM;
    end else begin
      v = STATUS_VALID;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/nsgc_line_scan.sv
// Per-line byte scanner: prefix match, XOR, checksum field parse, line end detection.
`default_nettype none

module nsgc_line_scan
  import nsgc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       byte_take,
  input  wire logic [7:0] rx_byte,
  input  wire logic [7:0] max_line_bytes,
  output line_end_t       line_end
);

  logic [7:0] line_pos_r,   line_pos_nxt;
  logic       prefix_ok_r,  prefix_ok_nxt;
  logic [7:0] xor_acc_r,    xor_acc_nxt;
  logic [1:0] star_cnt_r,   star_cnt_nxt;
  logic       tail_r,       tail_nxt;
  logic [7:0] hex_val_r,    hex_val_nxt;
  logic [1:0] hex_phase_r,  hex_phase_nxt;
  logic       hex_ovf_r,    hex_ovf_nxt;
  status_t    cr_verdict_r, cr_verdict_nxt;
  logic       cr_seen_r,    cr_seen_nxt;

  logic [7:0] limit;
  logic [8:0] length;
  logic [4:0] digit;
  logic       ended;
  status_t    verdict;

  assign limit  = (max_line_bytes == 8'd0) ? 8'd1 : max_line_bytes;
  assign length = {1'b0, line_pos_r} + 9'd1;
  assign digit  = hex_digit(rx_byte);

  always_comb begin
    prefix_ok_nxt  = prefix_ok_r;
    xor_acc_nxt    = xor_acc_r;
    star_cnt_nxt   = star_cnt_r;
    tail_nxt       = tail_r;
    hex_val_nxt    = hex_val_r;
    hex_phase_nxt  = hex_phase_r;
    hex_ovf_nxt    = hex_ovf_r;
    cr_verdict_nxt = cr_verdict_r;
    cr_seen_nxt    = cr_seen_r;

    // verdict frozen at the carriage return uses the state before it
    if (rx_byte == CHAR_CR) begin
      cr_verdict_nxt = line_verdict(star_cnt_r, tail_r, hex_ovf_r, hex_val_r, xor_acc_r);
      cr_seen_nxt    = 1'b1;
    end
    if (line_pos_r < PREFIX_LEN && rx_byte != rmc_prefix_char(line_pos_r[2:0])) begin
      prefix_ok_nxt = 1'b0;
    end
    if (rx_byte == CHAR_STAR) begin
      if (star_cnt_r != 2'd3) begin
        star_cnt_nxt = star_cnt_r + 2'd1;
      end
      tail_nxt = 1'b0;
    end else begin
      tail_nxt = 1'b1;
      if (star_cnt_r == 2'd0) begin
        if (line_pos_r != 8'd0) begin
          xor_acc_nxt = xor_acc_r ^ rx_byte;
        end
      end else if (star_cnt_r == 2'd1 && hex_phase_r != HEX_STOPPED) begin
        if (!digit[4]) begin
          hex_phase_nxt = HEX_STOPPED;
        end else begin
          if (hex_val_r[7:4] != 4'd0) begin
            hex_ovf_nxt = 1'b1;
          end
          hex_val_nxt   = {hex_val_r[3:0], digit[3:0]};
          hex_phase_nxt = HEX_DIGITS;
        end
      end
    end
  end

  assign ended   = (rx_byte == CHAR_LF) || (length >= {1'b0, limit});
  assign verdict = cr_seen_nxt ? cr_verdict_nxt
                 : line_verdict(star_cnt_nxt, tail_nxt, hex_ovf_nxt, hex_val_nxt, xor_acc_nxt);

  assign line_end.ended   = byte_take && ended;
  assign line_end.rmc     = prefix_ok_nxt && (length >= {1'b0, PREFIX_LEN});
  assign line_end.verdict = verdict;

  assign line_pos_nxt = length[7:0];

  always_ff @(posedge clk) begin
    if (!rst_n || (byte_take && ended)) begin
      line_pos_r   <= 8'd0;
      prefix_ok_r  <= 1'b1;
      xor_acc_r    <= 8'd0;
      star_cnt_r   <= 2'd0;
      tail_r       <= 1'b0;
      hex_val_r    <= 8'd0;
      hex_phase_r  <= HEX_NONE;
      hex_ovf_r    <= 1'b0;
      cr_verdict_r <= STATUS_VALID;
      cr_seen_r    <= 1'b0;
    end else if (byte_take) begin
      line_pos_r   <= line_pos_nxt;
      prefix_ok_r  <= prefix_ok_nxt;
      xor_acc_r    <= xor_acc_nxt;
      star_cnt_r   <= star_cnt_nxt;
      tail_r       <= tail_nxt;
      hex_val_r    <= hex_val_nxt;
      hex_phase_r  <= hex_phase_nxt;
      hex_ovf_r    <= hex_ovf_nxt;
      cr_verdict_r <= cr_verdict_nxt;
      cr_seen_r    <= cr_seen_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/nmea_sentence_group_checker_unit.sv
// Top level of the NMEA sentence group checker: config, group tracking, result register.
// A result request appears on out_* in the cycle after the byte that ends its line is taken.
// Throughput: one byte per cycle while in_stall is low; the scanner updates its line state in the accept cycle.
// in_stall rises only while a result is held and the consumer stalls it.
// Reset (rst_n low, synchronous): hunting for RMC, line state cleared, no result held,
// max_line_bytes back to 82 and sentences_per_group back to 6. No clearing pass.
`default_nettype none

module nmea_sentence_group_checker_unit
  import nsgc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  // byte requests
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  // result requests
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      out_slot,
  output logic [1:0]      out_status,
  output logic            out_group_done,
  // register writes
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_data
);

  logic [7:0] max_line_bytes_r;
  logic [3:0] group_size_r;

  logic [2:0] group_slot_r, group_slot_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [2:0] out_slot_r;
  status_t    out_status_r;
  logic       out_done_r;

  logic       byte_take;
  line_end_t  line_end;
  logic [3:0] group_size;
  logic       result_load;
  logic       group_done;

  // --- configuration: always ready, writes are registered
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_line_bytes_r <= LINE_BYTES_RST;
      group_size_r     <= GROUP_SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_LINE_BYTES:      max_line_bytes_r <= cfg_data;
        CFG_SENTENCES_PER_GROUP: group_size_r     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // out-of-range group sizes clamp to 1..8
  assign group_size = (group_size_r == 4'd0) ? 4'd1
                    : (group_size_r > GROUP_SIZE_MAX) ? GROUP_SIZE_MAX : group_size_r;

  // --- input side: hold off only while the result register is full and stalled
  assign in_stall  = out_valid_r && out_stall;
  assign byte_take = in_valid && !in_stall;

  nsgc_line_scan u_scan (
    .clk            (clk),
    .rst_n          (rst_n),
    .byte_take      (byte_take),
    .rx_byte        (in_rx_byte),
    .max_line_bytes (max_line_bytes_r),
    .line_end       (line_end)
  );

  // --- group tracking
  // While hunting (slot zero) only an RMC line produces a result.
  assign result_load = line_end.ended && (group_slot_r != 3'd0 || line_end.rmc);
  assign group_done  = (line_end.verdict == STATUS_VALID) &&
                       (({1'b0, group_slot_r} + 4'd1) >= group_size);

  always_comb begin
    group_slot_nxt = group_slot_r;
    if (result_load) begin
      if (line_end.verdict != STATUS_VALID || group_done) begin
        group_slot_nxt = 3'd0; // error or full group: back to hunting
      end else begin
        group_slot_nxt = group_slot_r + 3'd1;
      end
    end
  end

  // --- result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (result_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_slot_r <= 3'd0;
      out_valid_r  <= 1'b0;
    end else begin
      group_slot_r <= group_slot_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (result_load) begin
      out_slot_r   <= group_slot_r;
      out_status_r <= line_end.verdict;
      out_done_r   <= group_done;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_slot       = out_slot_r;
  assign out_status     = out_status_r;
  assign out_group_done = out_done_r;

  // --- checks
  // a finished group is only ever flagged on a valid sentence
  a_done_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_r |-> out_status_r == STATUS_VALID)
    else $error("group_done set on an error result");

  // input stall only comes from a held, stalled result
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with empty result register");

  // an error or a completed group restarts the hunt
  a_hunt_restart: assert property (@(posedge clk) disable iff (!rst_n)
    result_load && (line_end.verdict != STATUS_VALID || group_done) |=> group_slot_r == 3'd0)
    else $error("group slot not cleared after error or group end");

  // a result is never overwritten while it is being stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !result_load)
    else $error("result register overwritten while stalled");

endmodule

`default_nettype wire
